FILE: rtl/core/dtyc_pkg.sv
// Package for the differential thrust yaw controller: register indexes, reset
// values, sequencer state and operand codes, control struct, yaw error function.
// No dependencies.
package dtyc_pkg;

  localparam logic [2:0] REG_RATE_GAIN     = 3'd0;
  localparam logic [2:0] REG_ANGLE_GAIN    = 3'd1;
  localparam logic [2:0] REG_RATE_SCALE    = 3'd2;
  localparam logic [2:0] REG_LEAK_FACTOR   = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND     = 3'd4;
  localparam logic [2:0] REG_ACCEPT_MARGIN = 3'd5;

  localparam logic [15:0] RATE_GAIN_RST     = 16'd4096;
  localparam logic [15:0] ANGLE_GAIN_RST    = 16'd4096;
  localparam logic [15:0] RATE_SCALE_RST    = 16'd4096;
  localparam logic [13:0] LEAK_FACTOR_RST   = 14'd6554;
  localparam logic [13:0] DEAD_BAND_RST     = 14'd164;
  localparam logic [13:0] ACCEPT_MARGIN_RST = 14'd1638;

  // floor(n / 3) = (n * DIV3_RECIP) >> 17, exact for n below 2^17
  localparam logic signed [17:0] DIV3_RECIP = 18'sd43691;
  localparam logic signed [17:0] DIV3_OFFS  = 18'sd49155;
  localparam logic signed [17:0] DIV3_LIM   = 18'sd49155;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_LEAK,
    ST_LEAKERR,
    ST_STEP,
    ST_SETPT,
    ST_ACCEPT,
    ST_AGAIN,
    ST_MIXL,
    ST_QUOT,
    ST_DIVL,
    ST_DIVR,
    ST_RIGHT,
    ST_DONE
  } dtyc_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RATE,
    OP_LEAK,
    OP_LEAKERR,
    OP_STEP,
    OP_RGAIN,
    OP_AGAIN,
    OP_DIVL,
    OP_DIVR
  } dtyc_op_e;

  typedef struct packed {
    logic     in_ready;
    dtyc_op_e op;
    logic     take_rate;
    logic     take_acc;
    logic     take_x;
    logic     take_accept;
    logic     take_drive;
    logic     take_quot;
    logic     take_left;
    logic     take_right;
    logic     load_out;
  } dtyc_ctrl_t;

  function automatic logic [16:0] yaw_err(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] d;
    logic        [16:0] e1;
    logic signed [17:0] t;
    logic        [16:0] e2;
    d  = {a[15], a} - {b[15], b};
    e1 = d[16] ? 17'(-d) : 17'(d);
    t  = 18'sd32768 - $signed({1'b0, e1});
    e2 = t[17] ? 17'(-t) : 17'(t);
    return (e1 < e2) ? e1 : e2;
  endfunction

endpackage

FILE: rtl/core/dtyc_in_if.sv
// Input tick channel of the yaw controller: valid, ready and the tick fields.
// No dependencies.
interface dtyc_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] time_step;
  logic               manual_enabled;
  logic               stick_new;
  logic signed [15:0] stick_yaw;
  logic signed [15:0] stick_throttle;
  logic               yaw_new;
  logic signed [15:0] yaw_measured;
  logic               rate_new;
  logic signed [15:0] rate_measured;

  modport source (
    output valid, time_step, manual_enabled, stick_new, stick_yaw, stick_throttle,
           yaw_new, yaw_measured, rate_new, rate_measured,
    input  ready
  );
  modport sink (
    input  valid, time_step, manual_enabled, stick_new, stick_yaw, stick_throttle,
           yaw_new, yaw_measured, rate_new, rate_measured,
    output ready
  );
endinterface

FILE: rtl/core/dtyc_out_if.sv
// Thrust command channel of the yaw controller: valid, ready, left and right thrust.
// No dependencies.
interface dtyc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_thrust;
  logic signed [15:0] right_thrust;

  modport source (output valid, left_thrust, right_thrust, input ready);
  modport sink (input valid, left_thrust, right_thrust, output ready);
endinterface

FILE: rtl/core/dtyc_cfg_if.sv
// Register write channel of the yaw controller: valid, ready, index and data.
// No dependencies.
interface dtyc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dtyc_mul.sv
// Shared signed multiplier of the yaw controller, product registered.
// No dependencies.
module dtyc_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [49:0] p_o
);

  logic signed [49:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/dtyc_ctrl.sv
// Sequencer of the yaw controller: walks one tick through the multiplier steps.
// Depends on dtyc_pkg.
module dtyc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   enabled_i,
  input  logic                   stick_i,
  input  logic                   out_free_i,
  output dtyc_pkg::dtyc_ctrl_t   ctrl_o
);

  dtyc_pkg::dtyc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtyc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dtyc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!enabled_i) begin
            state_d = dtyc_pkg::ST_DONE;
          end else if (stick_i) begin
            state_d = dtyc_pkg::ST_RATE;
          end
        end
      end
      dtyc_pkg::ST_RATE:    state_d = dtyc_pkg::ST_LEAK;
      dtyc_pkg::ST_LEAK:    state_d = dtyc_pkg::ST_LEAKERR;
      dtyc_pkg::ST_LEAKERR: state_d = dtyc_pkg::ST_STEP;
      dtyc_pkg::ST_STEP:    state_d = dtyc_pkg::ST_SETPT;
      dtyc_pkg::ST_SETPT:   state_d = dtyc_pkg::ST_ACCEPT;
      dtyc_pkg::ST_ACCEPT:  state_d = dtyc_pkg::ST_AGAIN;
      dtyc_pkg::ST_AGAIN:   state_d = dtyc_pkg::ST_MIXL;
      dtyc_pkg::ST_MIXL:    state_d = dtyc_pkg::ST_QUOT;
      dtyc_pkg::ST_QUOT:    state_d = dtyc_pkg::ST_DIVL;
      dtyc_pkg::ST_DIVL:    state_d = dtyc_pkg::ST_DIVR;
      dtyc_pkg::ST_DIVR:    state_d = dtyc_pkg::ST_RIGHT;
      dtyc_pkg::ST_RIGHT:   state_d = dtyc_pkg::ST_DONE;
      dtyc_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = dtyc_pkg::ST_IDLE;
        end
      end
      default:              state_d = dtyc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o    = '0;
    ctrl_o.op = dtyc_pkg::OP_NONE;
    case (state_q)
      dtyc_pkg::ST_IDLE:    ctrl_o.in_ready = 1'b1;
      dtyc_pkg::ST_RATE:    ctrl_o.op = dtyc_pkg::OP_RATE;
      dtyc_pkg::ST_LEAK: begin
        ctrl_o.take_rate = 1'b1;
        ctrl_o.op        = dtyc_pkg::OP_LEAK;
      end
      dtyc_pkg::ST_LEAKERR: ctrl_o.op = dtyc_pkg::OP_LEAKERR;
      dtyc_pkg::ST_STEP: begin
        ctrl_o.take_acc = 1'b1;
        ctrl_o.op       = dtyc_pkg::OP_STEP;
      end
      dtyc_pkg::ST_SETPT: begin
        ctrl_o.take_x = 1'b1;
        ctrl_o.op     = dtyc_pkg::OP_RGAIN;
      end
      dtyc_pkg::ST_ACCEPT:  ctrl_o.take_accept = 1'b1;
      dtyc_pkg::ST_AGAIN:   ctrl_o.op = dtyc_pkg::OP_AGAIN;
      dtyc_pkg::ST_MIXL:    ctrl_o.take_drive = 1'b1;
      dtyc_pkg::ST_QUOT:    ctrl_o.take_quot = 1'b1;
      dtyc_pkg::ST_DIVL:    ctrl_o.op = dtyc_pkg::OP_DIVL;
      dtyc_pkg::ST_DIVR: begin
        ctrl_o.take_left = 1'b1;
        ctrl_o.op        = dtyc_pkg::OP_DIVR;
      end
      dtyc_pkg::ST_RIGHT:   ctrl_o.take_right = 1'b1;
      dtyc_pkg::ST_DONE:    ctrl_o.load_out = out_free_i;
      default:              ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/differential_thrust_yaw_controller_core.sv
// Differential thrust yaw controller, top level: registers, datapath, output stage.
// Depends on dtyc_pkg, dtyc_in_if, dtyc_out_if, dtyc_cfg_if, dtyc_ctrl, dtyc_mul.
// Enabled tick with fresh stick: result registered after the twelve sequencer steps
// around eight shared multiplier operations and ST_DONE, which waits while the output
// is stalled; the next tick is taken after that. Disabled tick: zero thrust, through
// ST_DONE only. Tick without fresh stick: no result, input stays ready. Reset:
// registers to defaults, yaw state zero, no result pending.
module differential_thrust_yaw_controller_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtyc_in_if.sink           in_i,
  dtyc_out_if.source        out_o,
  dtyc_cfg_if.sink          cfg_i
);

  dtyc_pkg::dtyc_ctrl_t ctrl;

  logic [15:0] rate_gain_q, angle_gain_q, rate_scale_q;
  logic [13:0] leak_q, dead_band_q, margin_q;

  logic signed [15:0] setpt_q, yaw_q, rate_q;
  logic               init_q;

  logic        [15:0] dt_q;
  logic signed [15:0] u_q, thr_q, rmeas_q;
  logic               rate_new_q;

  logic signed [51:0] acc_q;
  logic signed [19:0] xr_q;
  logic signed [35:0] drive_q;
  logic signed [17:0] ql_q, qr_q;
  logic signed [15:0] left_q, right_q;

  logic               out_valid_q;
  logic signed [15:0] out_left_q, out_right_q;

  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_p;

  logic               accept, out_free;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) begin
      return 16'sh7fff;
    end else if (v < -50'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
    if (v > 18'sd16384) begin
      return 16'sd16384;
    end else if (v < -18'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [17:0] clamp_quot(input logic signed [39:0] w);
    logic signed [27:0] q;
    q = w[39:12];
    if (q > 28'(dtyc_pkg::DIV3_LIM)) begin
      return dtyc_pkg::DIV3_LIM;
    end else if (q < -28'(dtyc_pkg::DIV3_LIM)) begin
      return -dtyc_pkg::DIV3_LIM;
    end
    return q[17:0];
  endfunction

  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && ctrl.in_ready;
  assign in_i.ready  = ctrl.in_ready;
  assign cfg_i.ready = 1'b1;

  dtyc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .enabled_i  (in_i.manual_enabled),
    .stick_i    (in_i.stick_new),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  dtyc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // operand select
  logic        [16:0] abs_u;
  logic signed [16:0] f_val, diff_sy, rerr;
  logic        [16:0] aerr_cur;
  logic signed [17:0] nl_sum, nr_sum;

  assign abs_u    = u_q[15] ? 17'(-{u_q[15], u_q}) : {1'b0, u_q};
  assign f_val    = (abs_u <= {3'b0, dead_band_q}) ? 17'sd0 : {u_q[15], u_q};
  assign diff_sy  = {setpt_q[15], setpt_q} - {yaw_q[15], yaw_q};
  assign rerr     = {u_q[15], u_q} - {rate_q[15], rate_q};
  assign aerr_cur = dtyc_pkg::yaw_err(setpt_q, yaw_q);
  assign nl_sum   = ql_q + dtyc_pkg::DIV3_OFFS;
  assign nr_sum   = qr_q + dtyc_pkg::DIV3_OFFS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      dtyc_pkg::OP_RATE: begin
        mul_a = {{16{rmeas_q[15]}}, rmeas_q};
        mul_b = {2'b0, rate_scale_q};
      end
      dtyc_pkg::OP_LEAK: begin
        mul_a = {16'b0, dt_q};
        mul_b = {4'b0, leak_q};
      end
      dtyc_pkg::OP_LEAKERR: begin
        mul_a = mul_p[31:0];
        mul_b = {diff_sy[16], diff_sy};
      end
      dtyc_pkg::OP_STEP: begin
        mul_a = {16'b0, dt_q};
        mul_b = {f_val[16], f_val};
      end
      dtyc_pkg::OP_RGAIN: begin
        mul_a = {16'b0, rate_gain_q};
        mul_b = {rerr[16], rerr};
      end
      dtyc_pkg::OP_AGAIN: begin
        mul_a = {16'b0, angle_gain_q};
        mul_b = u_q[15] ? -$signed({1'b0, aerr_cur}) : $signed({1'b0, aerr_cur});
      end
      dtyc_pkg::OP_DIVL: begin
        mul_a = {15'b0, nl_sum[16:0]};
        mul_b = dtyc_pkg::DIV3_RECIP;
      end
      dtyc_pkg::OP_DIVR: begin
        mul_a = {15'b0, nr_sum[16:0]};
        mul_b = dtyc_pkg::DIV3_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // step results
  logic signed [49:0] rate_rnd;
  logic signed [51:0] x_sum, x_rnd;
  logic signed [19:0] x_wrap;
  logic signed [15:0] x_sat;
  logic               x_ok;
  logic        [14:0] err_lim;
  logic signed [39:0] d40, d5, thr40, thrk, w_l, w_r;
  logic signed [17:0] res_div;

  assign rate_rnd = (mul_p + 50'sd512) >>> 10;
  assign x_sum    = acc_q + {mul_p[37:0], 14'b0};
  assign x_rnd    = x_sum + 52'sd536870912;

  always_comb begin
    if (xr_q > 20'sd16384) begin
      x_wrap = xr_q - 20'sd32768;
    end else if (xr_q < -20'sd16384) begin
      x_wrap = xr_q + 20'sd32768;
    end else begin
      x_wrap = xr_q;
    end
  end

  assign x_sat   = sat16({{30{x_wrap[19]}}, x_wrap});
  assign err_lim = 15'd16384 - {1'b0, margin_q};
  assign x_ok    = dtyc_pkg::yaw_err(x_sat, yaw_q) < {2'b0, err_lim};

  assign d40     = {{4{drive_q[35]}}, drive_q};
  assign d5      = (d40 <<< 2) + d40;
  assign thr40   = {{24{thr_q[15]}}, thr_q};
  assign thrk    = (thr40 <<< 13) + (thr40 <<< 12);
  assign w_l     = thrk + d5 + 40'sd6144;
  assign w_r     = thrk - d5 + 40'sd6144;
  assign res_div = $signed({1'b0, mul_p[33:17]}) - 18'sd16385;

  // configuration and yaw state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_gain_q  <= dtyc_pkg::RATE_GAIN_RST;
      angle_gain_q <= dtyc_pkg::ANGLE_GAIN_RST;
      rate_scale_q <= dtyc_pkg::RATE_SCALE_RST;
      leak_q       <= dtyc_pkg::LEAK_FACTOR_RST;
      dead_band_q  <= dtyc_pkg::DEAD_BAND_RST;
      margin_q     <= dtyc_pkg::ACCEPT_MARGIN_RST;
      setpt_q      <= '0;
      yaw_q        <= '0;
      rate_q       <= '0;
      init_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          dtyc_pkg::REG_RATE_GAIN:     rate_gain_q  <= cfg_i.data;
          dtyc_pkg::REG_ANGLE_GAIN:    angle_gain_q <= cfg_i.data;
          dtyc_pkg::REG_RATE_SCALE:    rate_scale_q <= cfg_i.data;
          dtyc_pkg::REG_LEAK_FACTOR:   leak_q       <= cfg_i.data[13:0];
          dtyc_pkg::REG_DEAD_BAND:     dead_band_q  <= cfg_i.data[13:0];
          dtyc_pkg::REG_ACCEPT_MARGIN: margin_q     <= cfg_i.data[13:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!in_i.manual_enabled) begin
          init_q <= 1'b0;
        end else if (in_i.stick_new && in_i.yaw_new) begin
          yaw_q <= in_i.yaw_measured;
          if (!init_q) begin
            setpt_q <= in_i.yaw_measured;
            init_q  <= 1'b1;
          end
        end
      end
      if (ctrl.take_rate && rate_new_q) begin
        rate_q <= sat16(rate_rnd);
      end
      if (ctrl.take_accept && x_ok) begin
        setpt_q <= x_sat;
      end
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tick operands and working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q       <= in_i.time_step;
      u_q        <= in_i.stick_yaw;
      thr_q      <= in_i.stick_throttle;
      rmeas_q    <= in_i.rate_measured;
      rate_new_q <= in_i.rate_new;
      if (!in_i.manual_enabled) begin
        left_q  <= '0;
        right_q <= '0;
      end
    end
    if (ctrl.take_acc) begin
      acc_q <= {{6{setpt_q[15]}}, setpt_q, 30'b0} - {{2{mul_p[49]}}, mul_p};
    end
    if (ctrl.take_x) begin
      xr_q <= x_rnd[49:30];
    end
    if (ctrl.take_accept) begin
      acc_q <= {{2{mul_p[49]}}, mul_p};
    end
    if (ctrl.take_drive) begin
      drive_q <= acc_q[35:0] + mul_p[35:0];
    end
    if (ctrl.take_quot) begin
      ql_q <= clamp_quot(w_l);
      qr_q <= clamp_quot(w_r);
    end
    if (ctrl.take_left) begin
      left_q <= clamp_unit(res_div);
    end
    if (ctrl.take_right) begin
      right_q <= clamp_unit(res_div);
    end
    if (ctrl.load_out) begin
      out_left_q  <= left_q;
      out_right_q <= right_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.left_thrust  = out_left_q;
  assign out_o.right_thrust = out_right_q;

endmodule

FILE: rtl/core/dtyc_chk.sv
// Port-level checker for the yaw controller and its bind to the top level.
// Depends on differential_thrust_yaw_controller_core.
module dtyc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               manual_i,
  input logic               stick_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] left_i,
  input logic signed [15:0] right_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (left_i <= 16'sd16384) && (left_i >= -16'sd16384) &&
                    (right_i <= 16'sd16384) && (right_i >= -16'sd16384))
    else $error("thrust outside unit range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (!manual_i || stick_i) |=> !in_ready_i)
    else $error("ready while a tick is in progress");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && manual_i && !stick_i |=> in_ready_i)
    else $error("tick without stick sample stalled input");

endmodule

bind differential_thrust_yaw_controller_core dtyc_chk u_dtyc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .manual_i    (in_i.manual_enabled),
  .stick_i     (in_i.stick_new),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_i      (out_o.left_thrust),
  .right_i     (out_o.right_thrust)
);
